/* hw/rtl/atcp_pkg.sv */
// ----------------------------------------------------------------------------
// atcp_pkg
// Shared types, codes and the colour palette of the text console parser.
// ----------------------------------------------------------------------------
`default_nettype none
package atcp_pkg;

   typedef enum logic [1:0] {
      CMD_GLYPH       = 2'd0,
      CMD_ERASE       = 2'd1,
      CMD_SCROLL_UP   = 2'd2,
      CMD_SCROLL_DOWN = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_COLUMNS = 1'b0,
      CSR_ROWS    = 1'b1
   } csr_idx_type;

   localparam logic [7:0] CHAR_ESC = 8'h1b;
   localparam logic [7:0] CHAR_BS  = 8'h08;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_FF  = 8'h0c;
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  cell_col;
      logic [7:0]  cell_row;
      logic [7:0]  rect_width;
      logic [7:0]  rect_height;
      logic [7:0]  glyph;
      logic [23:0] fore_rgb;
      logic [23:0] back_rgb;
      logic [7:0]  scroll_lines;
      logic        last;
   } rsp_type;

   // Palette: bright selects the upper half.
   function automatic logic [23:0] palette(input logic bright, input logic [2:0] code);
      logic [23:0] rgb;
      begin
         unique case ({bright, code})
            4'd0:  rgb = 24'h000000;
            4'd1:  rgb = 24'haa0000;
            4'd2:  rgb = 24'h00aa00;
            4'd3:  rgb = 24'haa5500;
            4'd4:  rgb = 24'h0000aa;
            4'd5:  rgb = 24'haa00aa;
            4'd6:  rgb = 24'h00aaaa;
            4'd7:  rgb = 24'haaaaaa;
            4'd8:  rgb = 24'h555555;
            4'd9:  rgb = 24'hff5555;
            4'd10: rgb = 24'h55ff55;
            4'd11: rgb = 24'hffff55;
            4'd12: rgb = 24'h5555ff;
            4'd13: rgb = 24'hff55ff;
            4'd14: rgb = 24'h55ffff;
            default: rgb = 24'hffffff;
         endcase
         return rgb;
      end
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/atcp_stream_if.sv */
// ----------------------------------------------------------------------------
// atcp_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none
interface atcp_stream_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/atcp_rsp_if.sv */
// ----------------------------------------------------------------------------
// atcp_rsp_if
// Valid/ready channel carrying one console command.
// ----------------------------------------------------------------------------
`default_nettype none
interface atcp_rsp_if;
   import atcp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ansi_text_console_parser.sv */
// ----------------------------------------------------------------------------
// ansi_text_console_parser
// Turns a stream of terminal bytes into cell-level display commands.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one text byte per request (req.data). Accepted when valid & ready.
//   rsp  : one command per request on rsp; a byte yields zero, one or two
//          commands, the final one carrying last.
//   csr  : csr_we/csr_index/csr_wdata write columns (0) and rows (1); write
//          only while idle.
// All per-byte work is one combinational pass from the parser state into a
// two-entry command buffer. A command appears on rsp the cycle after its
// byte is accepted. One byte per cycle is taken while the buffer drains;
// a byte with two commands holds off the next byte until its second command
// leaves, as the single output port passes one command at a time.
// Reset clears the cursor, parser flags and colours (white on black) and
// loads 40 columns by 30 rows. When the receiver stalls, the buffer holds
// and req.ready drops until there is room for a worst-case byte.
// ----------------------------------------------------------------------------
`default_nettype none
module ansi_text_console_parser
   import atcp_pkg::*;
#(
   parameter int COORD_BITS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   atcp_stream_if.sink req,
   atcp_rsp_if.source  rsp,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);
   localparam int CW = (COORD_BITS > 8) ? COORD_BITS : 8;
   localparam int XW = CW + 2;
   localparam logic [XW-1:0] CMAX = XW'((1 << COORD_BITS) - 1);

   logic [7:0] columns_ff, rows_ff;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic esc_ff, esc_in, csi_ff, csi_in, bad_ff, bad_in, sec_ff, sec_in;
   logic g1_ff, g1_in, g2_ff, g2_in;
   logic [7:0] a1_ff, a1_in, a2_ff, a2_in;
   logic [2:0] fc_ff, fc_in, bc_ff, bc_in;
   logic br_ff, br_in, inv_ff, inv_in;

   // Output buffer: two slots, slot 0 at the head.
   rsp_type buf_ff [2];
   logic [1:0] cnt_ff;
   rsp_type c0, c1;
   logic [1:0] n_cmd;

   wire take = req.valid & req.ready;
   wire pop  = rsp.valid & rsp.ready;
   assign req.ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);
   assign rsp.valid = cnt_ff != 2'd0;
   assign rsp.data  = buf_ff[0];

   // Clamp a signed wide value to 0..CMAX.
   function automatic logic [CW-1:0] clampc(input logic signed [XW-1:0] v);
      if (v < 0) return '0;
      if (v > $signed(CMAX)) return CW'(CMAX);
      return CW'(v);
   endfunction

   function automatic logic signed [XW-1:0] sx(input logic [CW-1:0] v);
      return $signed({2'b00, v});
   endfunction

   // Apply one SGR code to colour state.
   function automatic logic [7:0] sgr(input logic [7:0] code, input logic [7:0] st);
      // st = {fc[2:0], bc[2:0], br, inv}
      logic [7:0] o;
      o = st;
      if (code == 8'd0) o = {3'd7, 3'd0, 1'b0, 1'b0};
      else if (code == 8'd1) o[1] = 1'b1;
      else if (code == 8'd7) o[0] = 1'b1;
      else if (code == 8'd21) o[1] = 1'b0;
      else if (code == 8'd27) o[0] = 1'b0;
      else if (code >= 8'd30 && code <= 8'd37) o[7:5] = 3'(code - 8'd30);
      else if (code >= 8'd40 && code <= 8'd47) o[4:2] = 3'(code - 8'd40);
      return o;
   endfunction

   always_comb begin
      logic signed [XW-1:0] w, h, cc, cr, a1, a2, ln;
      logic [23:0] fg, bg;
      logic [7:0] c, st, v;
      logic [11:0] m;
      rsp_type e;
      logic text;
      col_in = col_ff; row_in = row_ff;
      esc_in = esc_ff; csi_in = csi_ff; bad_in = bad_ff; sec_in = sec_ff;
      g1_in = g1_ff; g2_in = g2_ff; a1_in = a1_ff; a2_in = a2_ff;
      fc_in = fc_ff; bc_in = bc_ff; br_in = br_ff; inv_in = inv_ff;
      c = req.data;
      w = (columns_ff == 8'd0) ? XW'(1) : $signed(XW'(columns_ff));
      h = (rows_ff == 8'd0) ? XW'(1) : $signed(XW'(rows_ff));
      cc = sx(col_ff); cr = sx(row_ff);
      a1 = g1_ff ? $signed(XW'(a1_ff)) : XW'(1);
      a2 = g2_ff ? $signed(XW'(a2_ff)) : XW'(1);
      fg = palette(br_ff, fc_ff);
      bg = palette(1'b0, bc_ff);
      e = '0;
      e.fore_rgb = inv_ff ? bg : fg;
      e.back_rgb = inv_ff ? fg : bg;
      c0 = e; c1 = e; n_cmd = 2'd0;
      text = 1'b0; st = 8'd0; v = 8'd0; m = 12'd0; ln = '0;
      if (c == CHAR_ESC) begin
         esc_in = 1'b1; csi_in = 1'b0;
      end else begin
         text = 1'b1;
         if (csi_ff) begin
            if (c >= "0" && c <= "9") begin
               text = 1'b0;
               v = sec_ff ? a2_ff : a1_ff;
               m = 12'(v) * 12'd10 + 12'(c - "0");
               v = (m > 12'd255) ? 8'd255 : m[7:0];
               if (sec_ff) begin a2_in = v; g2_in = 1'b1; end
               else begin a1_in = v; g1_in = 1'b1; end
            end else if (c == ";") begin
               text = 1'b0;
               if (sec_ff) bad_in = 1'b1; else sec_in = 1'b1;
            end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
               text = 1'b0;
               csi_in = 1'b0;
               if (!bad_ff) begin
                  priority case (c)
                     "A": row_in = clampc((cr - a1 < 0) ? XW'(0) : cr - a1);
                     "B": row_in = clampc((cr + a1 > h) ? h : cr + a1);
                     "C": col_in = clampc((cc + a1 > w) ? w : cc + a1);
                     "D": col_in = clampc((cc - a1 < 0) ? XW'(0) : cc - a1);
                     "E": begin
                        col_in = '0; row_in = clampc((cr + a1 > h) ? h : cr + a1);
                     end
                     "F": begin
                        col_in = '0; row_in = clampc((cr - a1 < 0) ? XW'(0) : cr - a1);
                     end
                     "G": col_in = clampc((a1 - XW'(1) < 0) ? XW'(0)
                                          : ((a1 - XW'(1) > w) ? w : a1 - XW'(1)));
                     "H", "f": begin
                        col_in = clampc((a2 - XW'(1) < 0) ? XW'(0)
                                        : ((a2 - XW'(1) > w) ? w : a2 - XW'(1)));
                        row_in = clampc((a1 - XW'(1) < 0) ? XW'(0)
                                        : ((a1 - XW'(1) > h) ? h : a1 - XW'(1)));
                     end
                     "J", "K": begin
                        v = g1_ff ? a1_ff : 8'd0;
                        e.command = CMD_ERASE;
                        if (v == 8'd0) begin
                           if (c == "J" && cr < h - 1) begin
                              e.cell_col = 8'd0; e.cell_row = 8'(cr + 1);
                              e.rect_width = 8'(w); e.rect_height = 8'(h - cr - 1);
                              c0 = e; n_cmd = 2'd1;
                           end
                           if (cc < w) begin
                              e.cell_col = 8'(cc); e.cell_row = 8'(cr);
                              e.rect_width = 8'(w - cc); e.rect_height = 8'd1;
                              if (n_cmd == 2'd0) c0 = e; else c1 = e;
                              n_cmd = n_cmd + 2'd1;
                           end
                        end else if (v == 8'd1) begin
                           if (c == "J" && cr != 0) begin
                              e.cell_col = 8'd0; e.cell_row = 8'd0;
                              e.rect_width = 8'(w); e.rect_height = 8'(cr);
                              c0 = e; n_cmd = 2'd1;
                           end
                           if (cc != 0) begin
                              e.cell_col = 8'd0; e.cell_row = 8'(cr);
                              e.rect_width = 8'(cc); e.rect_height = 8'd1;
                              if (n_cmd == 2'd0) c0 = e; else c1 = e;
                              n_cmd = n_cmd + 2'd1;
                           end
                        end else if (v == 8'd2) begin
                           if (c == "J") begin
                              e.cell_col = 8'd0; e.cell_row = 8'd0;
                              e.rect_width = 8'(w); e.rect_height = 8'(h);
                              c0 = e; n_cmd = 2'd1;
                           end else if (cr < h) begin
                              e.cell_col = 8'd0; e.cell_row = 8'(cr);
                              e.rect_width = 8'(w); e.rect_height = 8'd1;
                              c0 = e; n_cmd = 2'd1;
                           end
                        end
                     end
                     "S", "T": begin
                        e.rect_width = 8'(w); e.rect_height = 8'(h);
                        if (a1 >= h) begin
                           e.command = CMD_ERASE; c0 = e; n_cmd = 2'd1;
                        end else if (a1 > 0) begin
                           e.command = (c == "T") ? CMD_SCROLL_DOWN : CMD_SCROLL_UP;
                           e.scroll_lines = 8'(a1); c0 = e; n_cmd = 2'd1;
                        end
                     end
                     "m": begin
                        st = sgr(g1_ff ? a1_ff : 8'd0, {fc_ff, bc_ff, br_ff, inv_ff});
                        if (g2_ff) st = sgr(a2_ff, st);
                        {fc_in, bc_in, br_in, inv_in} = st;
                     end
                     default: ;
                  endcase
               end
            end else begin
               csi_in = 1'b0;
            end
         end
         if (text) begin
            if (esc_ff && c == "[") begin
               esc_in = 1'b0; csi_in = 1'b1; bad_in = 1'b0; sec_in = 1'b0;
               g1_in = 1'b0; g2_in = 1'b0; a1_in = 8'd0; a2_in = 8'd0;
            end else begin
               esc_in = 1'b0;
               e.rect_width = 8'd1; e.rect_height = 8'd1;
               unique case (c)
                  CHAR_BS: if (cc != 0) begin
                     col_in = CW'(cc - 1);
                     e.command = CMD_GLYPH; e.cell_col = 8'(cc - 1);
                     e.cell_row = 8'(cr); e.glyph = CHAR_SPACE;
                     c0 = e; n_cmd = 2'd1;
                  end
                  CHAR_LF: begin col_in = '0; row_in = clampc(cr + XW'(1)); end
                  CHAR_FF: begin
                     col_in = '0; row_in = '0;
                     e.command = CMD_ERASE; e.rect_width = 8'(w); e.rect_height = 8'(h);
                     c0 = e; n_cmd = 2'd1;
                  end
                  CHAR_CR: col_in = '0;
                  default: begin
                     if (cc >= w) begin cc = '0; cr = sx(clampc(cr + XW'(1))); end
                     if (cr >= h) begin
                        ln = cr - h + XW'(1);
                        c0.rect_width = 8'(w); c0.rect_height = 8'(h);
                        if (ln >= h) begin
                           c0.command = CMD_ERASE; n_cmd = 2'd1;
                        end else if (ln > 0) begin
                           c0.command = CMD_SCROLL_UP; c0.scroll_lines = 8'(ln);
                           n_cmd = 2'd1;
                        end
                        cr = sx(clampc(h - XW'(1)));
                     end
                     e.command = CMD_GLYPH; e.cell_col = 8'(cc); e.cell_row = 8'(cr);
                     e.glyph = c;
                     if (n_cmd == 2'd0) c0 = e; else c1 = e;
                     n_cmd = n_cmd + 2'd1;
                     row_in = CW'(cr);
                     col_in = clampc(cc + XW'(1));
                  end
               endcase
            end
         end
      end
      if (n_cmd == 2'd1) c0.last = 1'b1;
      if (n_cmd == 2'd2) c1.last = 1'b1;
   end

   // Hold state and buffer count.
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= 8'd40; rows_ff <= 8'd30;
         col_ff <= '0; row_ff <= '0;
         esc_ff <= 1'b0; csi_ff <= 1'b0; bad_ff <= 1'b0; sec_ff <= 1'b0;
         g1_ff <= 1'b0; g2_ff <= 1'b0; a1_ff <= 8'd0; a2_ff <= 8'd0;
         fc_ff <= 3'd7; bc_ff <= 3'd0; br_ff <= 1'b0; inv_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (csr_we) begin
            if (csr_idx_type'(csr_index) == CSR_COLUMNS) columns_ff <= csr_wdata;
            else rows_ff <= csr_wdata;
         end
         if (take) begin
            col_ff <= col_in; row_ff <= row_in;
            esc_ff <= esc_in; csi_ff <= csi_in; bad_ff <= bad_in; sec_ff <= sec_in;
            g1_ff <= g1_in; g2_ff <= g2_in; a1_ff <= a1_in; a2_ff <= a2_in;
            fc_ff <= fc_in; bc_ff <= bc_in; br_ff <= br_in; inv_ff <= inv_in;
         end
         // At take the buffer is empty or draining its last entry.
         if (take) cnt_ff <= n_cmd;
         else if (pop) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         buf_ff[0] <= c0; buf_ff[1] <= c1;
      end else if (pop) begin
         buf_ff[0] <= buf_ff[1];
      end
   end

   // Ready only with room for two commands.
   a_no_take_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !req.ready) else $error("accept with full buffer");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("buffer count overflow");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> buf_ff[0].last) else $error("final command lacks last");
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (pop && !take) |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("bad drain");

endmodule
`default_nettype wire
